// File: hw/rtl/rwcp_pkg.sv
package rwcp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [4:0] RIFF_HDR_BYTES  = 5'd12;
    localparam logic [4:0] RIFF_TAG_BYTES  = 5'd4;
    localparam logic [4:0] CHUNK_HDR_BYTES = 5'd8;
    localparam logic [4:0] FMT_KEEP        = 5'd16;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_TAG = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_NO_FMT  = 3'd3,
        ST_NO_DATA = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_PAY  = 3'd2,
        PH_DATA = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_byte;
        logic [2:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] samples_per_sec;
        logic [31:0] avg_bytes_per_sec;
        logic [15:0] frame_bytes;
        logic [15:0] sample_width;
        logic [31:0] payload_len;
        logic [31:0] riff_size;
    } out_beat_t;

    function automatic out_beat_t make_error(input status_t st);
        out_beat_t r;
        r        = '0;
        r.kind   = KIND_ERROR;
        r.status = st;
        return r;
    endfunction

endpackage

// File: hw/rtl/riff_wave_chunk_parser_core.sv
// RIFF/WAVE stream parser. Feed the file one byte per beat on byte_*, with
// last_byte set on the final byte; that mark closes the parse and rearms the
// block for the next file. Data-chunk payload bytes come out as KIND_DATA
// beats, then one KIND_HEADER beat (fmt fields, data size, RIFF size) or one
// KIND_ERROR beat with a status code; every file yields exactly one of these.
// The parser takes one byte per clock while the queue has room: each byte is
// parsed by a single layer of counter/compare logic against the parser state and
// its results (up to two) are pushed into a 4-entry result queue in the same
// cycle. byte_ready drops only while the queue holds more than two beats, i.e.
// when the result side stalls.
module riff_wave_chunk_parser_core
    import rwcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_beat_t  byte_data,
    output logic      result_valid,
    input  logic      result_ready,
    output out_beat_t result_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Parser state
    phase_t           phase_reg,      phase_next;
    logic [4:0]       hdr_count_reg,  hdr_count_next;
    logic [31:0]      chunk_tag_reg,  chunk_tag_next;
    logic [31:0]      chunk_len_reg,  chunk_len_next;
    logic [32:0]      bytes_left_reg, bytes_left_next;
    logic [4:0]       pay_idx_reg,    pay_idx_next;
    logic             fmt_found_reg,  fmt_found_next;
    logic [31:0]      fmt_len_reg,    fmt_len_next;
    logic [15:0][7:0] fmt_kept_reg,   fmt_kept_next;
    logic [31:0]      riff_len_reg,   riff_len_next;

    // Result queue
    out_beat_t          queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    logic       take;
    logic       pop;
    logic [7:0] b;

    // State as it stands after the byte, before the end mark is applied
    phase_t      ph_after;
    logic [32:0] bl_after;
    logic [31:0] len_after;
    logic        fmt_ok_after;
    logic        fmt_ok_cur;

    logic [1:0]  push_n;
    out_beat_t   push_a;
    out_beat_t   push_b;
    out_beat_t   step_a;
    out_beat_t   step_b;
    out_beat_t   fin_res;
    out_beat_t   hdr_res;
    logic [1:0]  step_n;
    logic        fin_valid;

    assign take       = byte_valid && byte_ready;
    assign pop        = result_valid && result_ready;
    assign b          = byte_data.byte_in;
    assign fmt_ok_cur = fmt_found_reg && (fmt_len_reg[31:4] != 28'd0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_count_next  = hdr_count_reg;
        chunk_tag_next  = chunk_tag_reg;
        chunk_len_next  = chunk_len_reg;
        bytes_left_next = bytes_left_reg;
        pay_idx_next    = pay_idx_reg;
        fmt_found_next  = fmt_found_reg;
        fmt_len_next    = fmt_len_reg;
        fmt_kept_next   = fmt_kept_reg;
        riff_len_next   = riff_len_reg;

        if (take)
        begin
            case (phase_reg)
                PH_RIFF:
                begin
                    // tag bytes shift in; length bytes land little-endian
                    if (hdr_count_reg < RIFF_TAG_BYTES || hdr_count_reg >= CHUNK_HDR_BYTES)
                    begin
                        chunk_tag_next = {chunk_tag_reg[23:0], b};
                    end
                    else
                    begin
                        riff_len_next[{hdr_count_reg[1:0], 3'b000} +: 8] = b;
                    end
                    hdr_count_next = hdr_count_reg + 5'd1;
                    if (hdr_count_next == RIFF_TAG_BYTES && chunk_tag_next != TAG_RIFF)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (hdr_count_next == RIFF_HDR_BYTES)
                    begin
                        hdr_count_next = 5'd0;
                        phase_next     = (chunk_tag_next == TAG_WAVE) ? PH_HDR : PH_DONE;
                    end
                end

                PH_HDR:
                begin
                    if (hdr_count_reg == 5'd0)
                    begin
                        chunk_tag_next = '0;
                        chunk_len_next = '0;
                    end
                    if (hdr_count_reg < RIFF_TAG_BYTES)
                    begin
                        chunk_tag_next = {chunk_tag_next[23:0], b};
                    end
                    else
                    begin
                        chunk_len_next[{hdr_count_reg[1:0], 3'b000} +: 8] = b;
                    end
                    hdr_count_next = hdr_count_reg + 5'd1;
                    if (hdr_count_next == CHUNK_HDR_BYTES)
                    begin
                        hdr_count_next = 5'd0;
                        pay_idx_next   = 5'd0;
                        if (chunk_tag_next == TAG_DATA)
                        begin
                            bytes_left_next = {1'b0, chunk_len_next};
                            phase_next = (chunk_len_next == 32'd0) ? PH_DONE : PH_DATA;
                        end
                        else
                        begin
                            if (chunk_tag_next == TAG_FMT)
                            begin
                                fmt_found_next = 1'b1;
                                fmt_len_next   = chunk_len_next;
                                fmt_kept_next  = '0;
                            end
                            // round odd lengths up to cover the pad byte
                            bytes_left_next = {1'b0, chunk_len_next}
                                            + {32'd0, chunk_len_next[0]};
                            phase_next = (chunk_len_next == 32'd0) ? PH_HDR : PH_PAY;
                        end
                    end
                end

                PH_PAY:
                begin
                    if (bytes_left_reg != 33'd0)
                    begin
                        if (chunk_tag_reg == TAG_FMT && pay_idx_reg < FMT_KEEP)
                        begin
                            fmt_kept_next[pay_idx_reg[3:0]] = b;
                            pay_idx_next = pay_idx_reg + 5'd1;
                        end
                        bytes_left_next = bytes_left_reg - 33'd1;
                    end
                    if (bytes_left_next == 33'd0)
                    begin
                        phase_next     = PH_HDR;
                        hdr_count_next = 5'd0;
                    end
                end

                PH_DATA:
                begin
                    if (bytes_left_reg != 33'd0)
                    begin
                        bytes_left_next = bytes_left_reg - 33'd1;
                    end
                    if (bytes_left_next == 33'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                end

                default:
                begin
                end
            endcase
        end

        ph_after     = phase_next;
        bl_after     = bytes_left_next;
        len_after    = chunk_len_next;
        fmt_ok_after = fmt_found_next && (fmt_len_next[31:4] != 28'd0);

        // end mark: drop everything and rearm
        if (take && byte_data.last_byte)
        begin
            phase_next      = PH_RIFF;
            hdr_count_next  = '0;
            chunk_tag_next  = '0;
            chunk_len_next  = '0;
            bytes_left_next = '0;
            pay_idx_next    = '0;
            fmt_found_next  = 1'b0;
            fmt_len_next    = '0;
            fmt_kept_next   = '0;
            riff_len_next   = '0;
        end
    end

    // ------------------------------------------------------------------
    // Results of the byte
    // ------------------------------------------------------------------
    always_comb
    begin
        hdr_res                   = '0;
        hdr_res.kind              = KIND_HEADER;
        hdr_res.status            = ST_OK;
        hdr_res.format_tag        = {fmt_kept_reg[1],  fmt_kept_reg[0]};
        hdr_res.channels          = {fmt_kept_reg[3],  fmt_kept_reg[2]};
        hdr_res.samples_per_sec   = {fmt_kept_reg[7],  fmt_kept_reg[6],
                                     fmt_kept_reg[5],  fmt_kept_reg[4]};
        hdr_res.avg_bytes_per_sec = {fmt_kept_reg[11], fmt_kept_reg[10],
                                     fmt_kept_reg[9],  fmt_kept_reg[8]};
        hdr_res.frame_bytes       = {fmt_kept_reg[13], fmt_kept_reg[12]};
        hdr_res.sample_width      = {fmt_kept_reg[15], fmt_kept_reg[14]};
        hdr_res.payload_len       = chunk_len_reg;
        hdr_res.riff_size         = riff_len_reg;

        step_n = 2'd0;
        step_a = '0;
        step_b = '0;
        case (phase_reg)
            PH_RIFF:
            begin
                if (ph_after == PH_DONE)
                begin
                    step_n = 2'd1;
                    step_a = make_error(ST_BAD_TAG);
                end
            end
            PH_HDR:
            begin
                // a data chunk of length zero
                if (ph_after == PH_DONE)
                begin
                    step_n = 2'd1;
                    step_a = make_error(fmt_ok_cur ? ST_NO_DATA : ST_NO_FMT);
                end
            end
            PH_DATA:
            begin
                step_n             = 2'd1;
                step_a.kind        = KIND_DATA;
                step_a.sample_byte = b;
                if (ph_after == PH_DONE)
                begin
                    step_n = 2'd2;
                    step_b = fmt_ok_cur ? hdr_res : make_error(ST_NO_FMT);
                end
            end
            default:
            begin
            end
        endcase

        fin_valid = 1'b0;
        fin_res   = '0;
        if (byte_data.last_byte)
        begin
            if (ph_after == PH_RIFF)
            begin
                fin_valid = 1'b1;
                fin_res   = make_error(ST_BAD_TAG);
            end
            else if (ph_after == PH_DATA ||
                     (ph_after == PH_PAY && bl_after > {32'd0, len_after[0]}))
            begin
                fin_valid = 1'b1;
                fin_res   = make_error(ST_TRUNC);
            end
            else if (ph_after != PH_DONE)
            begin
                fin_valid = 1'b1;
                fin_res   = make_error(fmt_ok_after ? ST_NO_DATA : ST_NO_FMT);
            end
        end

        push_a = (step_n != 2'd0) ? step_a : fin_res;
        push_b = (step_n == 2'd2) ? step_b : fin_res;
        push_n = take ? (step_n + {1'b0, fin_valid}) : 2'd0;
    end

    // ------------------------------------------------------------------
    // Result queue: room for two pushes keeps the input open
    // ------------------------------------------------------------------
    assign byte_ready   = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result_data  = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            queue_mem[wr_ptr_reg + PTR_W'(1)] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RIFF;
            hdr_count_reg  <= '0;
            chunk_tag_reg  <= '0;
            chunk_len_reg  <= '0;
            bytes_left_reg <= '0;
            pay_idx_reg    <= '0;
            fmt_found_reg  <= 1'b0;
            fmt_len_reg    <= '0;
            fmt_kept_reg   <= '0;
            riff_len_reg   <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_count_reg  <= hdr_count_next;
            chunk_tag_reg  <= chunk_tag_next;
            chunk_len_reg  <= chunk_len_next;
            bytes_left_reg <= bytes_left_next;
            pay_idx_reg    <= pay_idx_next;
            fmt_found_reg  <= fmt_found_next;
            fmt_len_reg    <= fmt_len_next;
            fmt_kept_reg   <= fmt_kept_next;
            riff_len_reg   <= riff_len_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

endmodule
